>>> rtl/tawc_pkg.sv
`default_nettype none

package tawc_pkg;

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int WHOLE_W  = 13;
  localparam int NUMBER_W = 8;
  localparam int AGE_W    = 8;
  localparam int CFG_IDX_W = 8;

  // Default history length.
  localparam int HISTORY_DEPTH_DEF = 23;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_LOW    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_HIGH   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_LIMIT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SHOT      = 8'd3;

  // Register values after reset.
  localparam logic signed [SAMPLE_W-1:0] NORMAL_LOW_RST    = 16'sd185;
  localparam logic signed [SAMPLE_W-1:0] NORMAL_HIGH_RST   = 16'sd255;
  localparam logic [AGE_W-1:0]           HOLDOFF_LIMIT_RST = 8'd2;
  localparam logic                       ONE_SHOT_RST      = 1'b1;

  // Alarm kinds.
  localparam logic KIND_COLD = 1'b0;
  localparam logic KIND_HOT  = 1'b1;

  // Divide by ten: (x * 0xCCCD) >> 19 is exact for any 16-bit unsigned x.
  localparam logic [SAMPLE_W-1:0] DIV10_RECIP = 16'hCCCD;
  localparam int                  DIV10_SHIFT = 19;

  // Per-word control handed from the sequencer to the output stage.
  typedef struct packed {
    logic                kind;
    logic [NUMBER_W-1:0] number;
    logic                last;
  } word_ctl_t;

endpackage

`default_nettype wire

>>> rtl/tawc_cell.sv
`default_nettype none

// One history entry. It takes its neighbor's value on every shift.
module tawc_cell
  import tawc_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       shift,
  input  wire logic signed [SAMPLE_W-1:0] d,
  output logic signed [SAMPLE_W-1:0]      q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tawc_out_stage.sv
`default_nettype none

// Output register. It takes the oldest entry off the chain, divides it by ten
// and holds the word until the consumer takes it.
module tawc_out_stage
  import tawc_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  localparam int POS_W = $clog2(HISTORY_DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       load,
  input  wire word_ctl_t                  ctl,
  input  wire logic [POS_W-1:0]           pos,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  output logic                            can_load,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            alarm_kind,
  output logic [NUMBER_W-1:0]             alarm_number,
  output logic [POS_W-1:0]                position,
  output logic signed [SAMPLE_W-1:0]      history_sample,
  output logic signed [WHOLE_W-1:0]       whole_degrees,
  output logic                            last
);

  logic                  neg;
  logic [SAMPLE_W-1:0]   mag;
  logic [2*SAMPLE_W-1:0] prod;
  logic [WHOLE_W-1:0]    quot;
  logic [WHOLE_W-1:0]    whole;

  // Truncating division by ten on the magnitude, sign applied afterwards.
  always_comb begin
    neg   = sample[SAMPLE_W-1];
    mag   = neg ? (~sample + 1'b1) : sample;
    prod  = mag * DIV10_RECIP;
    quot  = prod[DIV10_SHIFT +: WHOLE_W];
    whole = neg ? (~quot + 1'b1) : quot;
  end

  assign can_load = !out_valid || out_ready;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (load) begin
      alarm_kind     <= ctl.kind;
      alarm_number   <= ctl.number;
      last           <= ctl.last;
      position       <= pos;
      history_sample <= sample;
      whole_degrees  <= whole;
    end
  end

endmodule

`default_nettype wire

>>> rtl/temp_alarm_window_capture_unit.sv
`default_nettype none

// The first dump word enters the output register once the alarm sample is accepted and
// the output register is empty or the previous dump's last word is being taken.
// Samples without alarm go in back to back; an alarm dumps HISTORY_DEPTH history words,
// one word per cycle while out_ready holds, as the history chain rotates once.
// Reset is synchronous; it clears the whole history chain, hold-off and sequence, and
// loads the config registers with reset values; the block takes samples right after.
module temp_alarm_window_capture_unit
  import tawc_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  localparam int POS_W = $clog2(HISTORY_DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [SAMPLE_W-1:0]        cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [SAMPLE_W-1:0] temperature,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            alarm_kind,
  output logic [NUMBER_W-1:0]             alarm_number,
  output logic [POS_W-1:0]                position,
  output logic signed [SAMPLE_W-1:0]      history_sample,
  output logic signed [WHOLE_W-1:0]       whole_degrees,
  output logic                            last
);

  typedef enum logic {IDLE, DUMP} state_t;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(HISTORY_DEPTH - 1);

  state_t                       state;
  logic [POS_W-1:0]             pos;
  logic                         kind;
  logic [NUMBER_W-1:0]          number;
  logic [NUMBER_W-1:0]          alarm_count;
  logic [AGE_W-1:0]             holdoff_age;
  logic                         fired_once;
  logic signed [SAMPLE_W-1:0]   normal_low;
  logic signed [SAMPLE_W-1:0]   normal_high;
  logic [AGE_W-1:0]             holdoff_limit;
  logic                         one_shot;

  logic                         in_acc;
  logic                         advance;
  logic                         can_load;
  logic                         below;
  logic                         above;
  logic                         fire;
  logic                         shift;
  logic signed [SAMPLE_W-1:0]   chain_in;
  logic signed [SAMPLE_W-1:0]   hist [HISTORY_DEPTH];
  word_ctl_t                    ctl;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == IDLE);
  assign in_acc    = in_valid && in_ready;
  assign advance   = (state == DUMP) && can_load;

  // Alarm decision on the incoming sample.
  always_comb begin
    below = temperature < normal_low;
    above = temperature > normal_high;
    fire  = (below || above)
         && ((holdoff_age == '0) || (holdoff_age > holdoff_limit))
         && !(one_shot && fired_once);
  end

  // The chain takes a new sample at the head, or rotates its tail back to the head.
  assign shift    = in_acc || advance;
  assign chain_in = in_acc ? temperature : hist[HISTORY_DEPTH-1];

  // History chain: cell 0 is the newest entry, the last cell the oldest.
  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    tawc_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     ((i == 0) ? chain_in : hist[(i == 0) ? 0 : i - 1]),
      .q     (hist[i])
    );
  end

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_low    <= NORMAL_LOW_RST;
      normal_high   <= NORMAL_HIGH_RST;
      holdoff_limit <= HOLDOFF_LIMIT_RST;
      one_shot      <= ONE_SHOT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NORMAL_LOW:    normal_low    <= cfg_data;
        REG_NORMAL_HIGH:   normal_high   <= cfg_data;
        REG_HOLDOFF_LIMIT: holdoff_limit <= cfg_data[AGE_W-1:0];
        REG_ONE_SHOT:      one_shot      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer: alarm bookkeeping and the dump walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      pos         <= '0;
      kind        <= KIND_COLD;
      number      <= '0;
      alarm_count <= '0;
      holdoff_age <= '0;
      fired_once  <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_acc) begin
            if (fire) begin
              state       <= DUMP;
              pos         <= '0;
              kind        <= below ? KIND_COLD : KIND_HOT;
              number      <= alarm_count;
              alarm_count <= alarm_count + 1'b1;
              holdoff_age <= AGE_W'(1);
              fired_once  <= 1'b1;
            end else if (holdoff_age <= holdoff_limit && holdoff_age != '1) begin
              holdoff_age <= holdoff_age + 1'b1;
            end
          end
        end
        DUMP: begin
          if (advance) begin
            if (pos == POS_LAST) begin
              state <= IDLE;
            end else begin
              pos <= pos + 1'b1;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_comb begin
    ctl.kind   = kind;
    ctl.number = number;
    ctl.last   = (pos == POS_LAST);
  end

  tawc_out_stage #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_out (
    .clk            (clk),
    .rst            (rst),
    .load           (advance),
    .ctl            (ctl),
    .pos            (pos),
    .sample         (hist[HISTORY_DEPTH-1]),
    .can_load       (can_load),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .alarm_kind     (alarm_kind),
    .alarm_number   (alarm_number),
    .position       (position),
    .history_sample (history_sample),
    .whole_degrees  (whole_degrees),
    .last           (last)
  );

endmodule

`default_nettype wire
